// ----- rtl/indexed_min_heap_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Indexed min-heap assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while reset is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_UNIT_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define IMH_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define IMH_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define IMH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/imh_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed min-heap package
// Widths, codes and request types shared by the heap store, the key map and
// the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package imh_pkg;

  localparam int CAPACITY = 256;
  localparam int PRIO_W   = 32;
  localparam int KEY_W    = 8;
  localparam int NKEYS    = 1 << KEY_W;
  localparam int SLOT_W   = $clog2(CAPACITY + 1);  // slots 1..CAPACITY
  localparam int ADDR_W   = $clog2(CAPACITY);      // slot CAPACITY folds onto 0

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_DECREASE = 2'd1,
    ACT_EXTRACT  = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_KEY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] pri;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            entry;
  } heap_wr_t;

  typedef struct packed {
    logic              en;
    logic              set;   // low clears the key
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } slot_wr_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot);
    slot_addr = slot[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/imh_heap_ram.sv -----
// ----------------------------------------------------------------------------
// Heap store
// One write port and one read port with registered read data, holding the
// (key, priority) entry of every heap slot.
// ----------------------------------------------------------------------------
`default_nettype none

module imh_heap_ram (
  input  wire logic                       clk,
  input  wire imh_pkg::heap_wr_t          wr,
  input  wire logic [imh_pkg::ADDR_W-1:0] rd_addr,
  output imh_pkg::entry_t                 rd_data
);

  imh_pkg::entry_t mem [imh_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/imh_slot_map.sv -----
// ----------------------------------------------------------------------------
// Key position map
// Heap slot of every key, with one valid bit per key so that reset empties
// the map at once. A key without its valid bit reads as slot zero.
// ----------------------------------------------------------------------------
`default_nettype none

module imh_slot_map (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire imh_pkg::slot_wr_t          wr,
  input  wire logic [imh_pkg::KEY_W-1:0]  rd_key,
  output logic      [imh_pkg::SLOT_W-1:0] rd_slot
);

  logic [imh_pkg::SLOT_W-1:0] mem [imh_pkg::NKEYS];
  logic [imh_pkg::NKEYS-1:0]  valid_r;
  logic [imh_pkg::SLOT_W-1:0] rd_slot_r;
  logic                       rd_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.key] <= wr.set;
      end
      rd_valid_r <= valid_r[rd_key];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.set) begin
      mem[wr.key] <= wr.slot;
    end
    rd_slot_r <= mem[rd_key];
  end

  assign rd_slot = rd_valid_r ? rd_slot_r : '0;

endmodule

`default_nettype wire

// ----- rtl/indexed_min_heap_unit.sv -----
// Flow: a rejected request, an unused code or an extract that empties the heap goes from the
// lookup straight to the reply; insert and decrease climb level by level from the hole, and an
// extract moves the last entry to the root and sinks it level by level.
// Throughput: one request at a time, held while a reply waits; the heap read port and the one
// priority comparator serve once per level climbed and twice per level descended.
// Reset (synchronous, rst_n low) empties the heap at once; no clearing pass.
// ----------------------------------------------------------------------------
// Indexed min-heap unit
// Binary min-heap of (key, priority) entries with a key-to-slot map, serving
// insert, decrease-key and extract-minimum requests over streaming channels.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_min_heap_unit_assert.svh"

module indexed_min_heap_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [7:0] key, [39:8] priority_req
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [7:0] out_key, [39:8] out_priority
  output logic [1:0]       out_tuser   // [1:0] status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_EX_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_FIN
  } state_t;

  localparam int SW = imh_pkg::SLOT_W;

  state_t                      state_r, state_nxt;
  imh_pkg::action_t            act_r, act_nxt;
  imh_pkg::entry_t             ent_r, ent_nxt;     // entry being placed
  imh_pkg::entry_t             child_r, child_nxt; // left child during sift-down
  logic                        lt_le_r, lt_le_nxt; // left child below moving entry
  logic [SW-1:0]               s_r, s_nxt;         // current hole slot
  logic [SW-1:0]               count_r, count_nxt;
  imh_pkg::status_t            res_st_r, res_st_nxt;
  imh_pkg::entry_t             res_ent_r, res_ent_nxt;
  logic                        out_valid_r;
  imh_pkg::status_t            out_st_r;
  imh_pkg::entry_t             out_ent_r;

  imh_pkg::heap_wr_t           heap_wr;
  logic [imh_pkg::ADDR_W-1:0]  heap_rd_addr;
  imh_pkg::entry_t             heap_rd;
  imh_pkg::slot_wr_t           slot_wr;
  logic [imh_pkg::KEY_W-1:0]   slot_rd_key;
  logic [SW-1:0]               slot_rd;

  logic [imh_pkg::PRIO_W-1:0]  cmp_a, cmp_b;
  logic                        cmp_lt;
  logic [SW:0]                 left_slot, right_slot;
  logic                        in_fire, out_free;

  imh_heap_ram u_heap (
    .clk     (clk),
    .wr      (heap_wr),
    .rd_addr (heap_rd_addr),
    .rd_data (heap_rd)
  );

  imh_slot_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (slot_wr),
    .rd_key  (slot_rd_key),
    .rd_slot (slot_rd)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign left_slot  = {s_r, 1'b0};
  assign right_slot = left_slot + {{SW{1'b0}}, 1'b1};

  // Shared priority comparator: cmp_lt = (cmp_a < cmp_b)
  always_comb begin
    cmp_a = ent_r.pri;
    cmp_b = ent_r.pri;
    unique case (state_r)
      S_UP_CMP: begin
        cmp_a = ent_r.pri;
        cmp_b = heap_rd.pri;
      end
      S_DN_R: begin
        cmp_a = heap_rd.pri;
        cmp_b = ent_r.pri;
      end
      S_DN_CMP: begin
        cmp_a = heap_rd.pri;
        cmp_b = lt_le_r ? child_r.pri : ent_r.pri;
      end
      default: begin
        cmp_a = ent_r.pri;
        cmp_b = ent_r.pri;
      end
    endcase
  end

  assign cmp_lt = (cmp_a < cmp_b);

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    ent_nxt      = ent_r;
    child_nxt    = child_r;
    lt_le_nxt    = lt_le_r;
    s_nxt        = s_r;
    count_nxt    = count_r;
    res_st_nxt   = res_st_r;
    res_ent_nxt  = res_ent_r;
    heap_wr      = '0;
    heap_rd_addr = imh_pkg::slot_addr(s_r);
    slot_wr      = '0;
    slot_rd_key  = in_tdata[7:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt      = imh_pkg::action_t'(in_tuser);
          ent_nxt.key  = in_tdata[7:0];
          ent_nxt.pri  = in_tdata[39:8];
          res_st_nxt   = imh_pkg::ST_OK;
          res_ent_nxt  = '0;
          heap_rd_addr = imh_pkg::slot_addr(SW'(1));  // root, for extract
          state_nxt    = S_LOOKUP;
        end
      end

      S_LOOKUP: begin
        unique case (act_r)
          imh_pkg::ACT_INSERT: begin
            if (slot_rd != '0) begin
              res_st_nxt = imh_pkg::ST_KEY;
              state_nxt  = S_FIN;
            end else if (count_r == SW'(imh_pkg::CAPACITY)) begin
              res_st_nxt = imh_pkg::ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              count_nxt = count_r + SW'(1);
              s_nxt     = count_r + SW'(1);
              state_nxt = S_UP_RD;
            end
          end
          imh_pkg::ACT_DECREASE: begin
            if (slot_rd == '0 || slot_rd > count_r) begin
              res_st_nxt = imh_pkg::ST_KEY;
              state_nxt  = S_FIN;
            end else begin
              s_nxt     = slot_rd;
              state_nxt = S_UP_RD;
            end
          end
          imh_pkg::ACT_EXTRACT: begin
            if (count_r == '0) begin
              res_st_nxt = imh_pkg::ST_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              res_ent_nxt = heap_rd;
              slot_wr.en  = 1'b1;
              slot_wr.set = 1'b0;
              slot_wr.key = heap_rd.key;
              count_nxt   = count_r - SW'(1);
              if (count_r > SW'(1)) begin
                heap_rd_addr = imh_pkg::slot_addr(count_r);  // last entry
                state_nxt    = S_EX_LAST;
              end else begin
                state_nxt = S_FIN;
              end
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      S_EX_LAST: begin
        ent_nxt   = heap_rd;
        s_nxt     = SW'(1);
        state_nxt = S_DN_L;
      end

      S_UP_RD: begin
        if (s_r == SW'(1)) begin
          heap_wr      = '{en: 1'b1, addr: imh_pkg::slot_addr(s_r), entry: ent_r};
          slot_wr      = '{en: 1'b1, set: 1'b1, key: ent_r.key, slot: s_r};
          state_nxt    = S_FIN;
        end else begin
          heap_rd_addr = imh_pkg::slot_addr({1'b0, s_r[SW-1:1]});
          state_nxt    = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        if (cmp_lt) begin
          // pull the parent down into the hole
          heap_wr   = '{en: 1'b1, addr: imh_pkg::slot_addr(s_r), entry: heap_rd};
          slot_wr   = '{en: 1'b1, set: 1'b1, key: heap_rd.key, slot: s_r};
          s_nxt     = {1'b0, s_r[SW-1:1]};
          state_nxt = S_UP_RD;
        end else begin
          heap_wr   = '{en: 1'b1, addr: imh_pkg::slot_addr(s_r), entry: ent_r};
          slot_wr   = '{en: 1'b1, set: 1'b1, key: ent_r.key, slot: s_r};
          state_nxt = S_FIN;
        end
      end

      S_DN_L: begin
        if (left_slot > {1'b0, count_r}) begin
          heap_wr   = '{en: 1'b1, addr: imh_pkg::slot_addr(s_r), entry: ent_r};
          slot_wr   = '{en: 1'b1, set: 1'b1, key: ent_r.key, slot: s_r};
          state_nxt = S_FIN;
        end else begin
          heap_rd_addr = imh_pkg::slot_addr(left_slot[SW-1:0]);
          state_nxt    = S_DN_R;
        end
      end

      S_DN_R: begin
        child_nxt = heap_rd;
        lt_le_nxt = cmp_lt;
        if (right_slot <= {1'b0, count_r}) begin
          heap_rd_addr = imh_pkg::slot_addr(right_slot[SW-1:0]);
          state_nxt    = S_DN_CMP;
        end else if (cmp_lt) begin
          heap_wr   = '{en: 1'b1, addr: imh_pkg::slot_addr(s_r), entry: heap_rd};
          slot_wr   = '{en: 1'b1, set: 1'b1, key: heap_rd.key, slot: s_r};
          s_nxt     = left_slot[SW-1:0];
          state_nxt = S_DN_L;
        end else begin
          heap_wr   = '{en: 1'b1, addr: imh_pkg::slot_addr(s_r), entry: ent_r};
          slot_wr   = '{en: 1'b1, set: 1'b1, key: ent_r.key, slot: s_r};
          state_nxt = S_FIN;
        end
      end

      S_DN_CMP: begin
        // left wins a tie; right moves up only when strictly smaller
        if (cmp_lt) begin
          heap_wr   = '{en: 1'b1, addr: imh_pkg::slot_addr(s_r), entry: heap_rd};
          slot_wr   = '{en: 1'b1, set: 1'b1, key: heap_rd.key, slot: s_r};
          s_nxt     = right_slot[SW-1:0];
          state_nxt = S_DN_L;
        end else if (lt_le_r) begin
          heap_wr   = '{en: 1'b1, addr: imh_pkg::slot_addr(s_r), entry: child_r};
          slot_wr   = '{en: 1'b1, set: 1'b1, key: child_r.key, slot: s_r};
          s_nxt     = left_slot[SW-1:0];
          state_nxt = S_DN_L;
        end else begin
          heap_wr   = '{en: 1'b1, addr: imh_pkg::slot_addr(s_r), entry: ent_r};
          slot_wr   = '{en: 1'b1, set: 1'b1, key: ent_r.key, slot: s_r};
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // hold until the output register frees up
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      act_r     <= act_nxt;
      ent_r     <= ent_nxt;
      child_r   <= child_nxt;
      lt_le_r   <= lt_le_nxt;
      s_r       <= s_nxt;
      res_st_r  <= res_st_nxt;
      res_ent_r <= res_ent_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
        out_st_r    <= res_st_r;
        out_ent_r   <= res_ent_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ent_r.pri, out_ent_r.key};
  assign out_tuser  = out_st_r;

  `IMH_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= SW'(imh_pkg::CAPACITY),
    "entry count beyond capacity")
  `IMH_ASSERT_NEXT(a_accept_lookup, clk, rst_n, in_fire, state_r == S_LOOKUP,
    "accepted request did not start a lookup")
  `IMH_ASSERT_IMPLIES(a_err_zero, clk, rst_n,
    out_valid_r && out_st_r != imh_pkg::ST_OK, out_ent_r == '0,
    "failed request carries nonzero key or priority")
  `IMH_ASSERT_IMPLIES(a_map_tracks_heap, clk, rst_n, heap_wr.en,
    slot_wr.en && slot_wr.set && slot_wr.key == heap_wr.entry.key &&
    imh_pkg::slot_addr(slot_wr.slot) == heap_wr.addr,
    "heap write without matching key map update")
  `IMH_ASSERT_IMPLIES(a_slot_nonzero, clk, rst_n,
    state_r == S_UP_RD || state_r == S_UP_CMP || state_r == S_DN_L ||
    state_r == S_DN_R || state_r == S_DN_CMP,
    s_r != '0 && s_r <= count_r,
    "sift slot outside the heap")

endmodule

`default_nettype wire

// ----- sim/imh_reply_checker.sv -----
// ----------------------------------------------------------------------------
// Indexed min-heap reply checker
// Watches both stream channels of the heap unit. It keeps its own copy of the
// heap and the key-to-slot map, works out the reply of every accepted request
// and compares each returned reply, in order, with the oldest one due.
// ----------------------------------------------------------------------------
module imh_reply_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] key, [39:8] priority_req
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [7:0] out_key, [39:8] out_priority
  input  logic [1:0]  out_tuser,  // [1:0] status
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;
  localparam int KW           = imh_pkg::KEY_W;
  localparam int PW           = imh_pkg::PRIO_W;
  localparam int SLW          = imh_pkg::SLOT_W;
  localparam int CAP          = imh_pkg::CAPACITY;

  typedef struct packed {
    imh_pkg::status_t status;
    logic [KW-1:0]    key;
    logic [PW-1:0]    pri;
  } heap_reply_t;

  // Shadow heap, slots 1..CAPACITY, and the key-to-slot map (0 = absent).
  logic [KW-1:0]  slot_key [1:CAP];
  logic [PW-1:0]  slot_pri [1:CAP];
  logic [SLW-1:0] key_slot [0:imh_pkg::NKEYS-1];
  int             entry_total = 0;

  heap_reply_t replies_due[$];
  int          failures = 0;

  function automatic void swap_slots(int a, int b);
    logic [KW-1:0] k;
    logic [PW-1:0] p;
    k = slot_key[a];
    p = slot_pri[a];
    slot_key[a] = slot_key[b];
    slot_pri[a] = slot_pri[b];
    slot_key[b] = k;
    slot_pri[b] = p;
    key_slot[slot_key[a]] = SLW'(a);
    key_slot[slot_key[b]] = SLW'(b);
  endfunction

  function automatic void climb(int s);
    while (s > 1 && slot_pri[s / 2] > slot_pri[s]) begin
      swap_slots(s, s / 2);
      s = s / 2;
    end
  endfunction

  // Strict compares; on a tie between two smaller children the left one wins.
  function automatic void sink(int s);
    int l;
    int r;
    int m;
    bit moving;
    moving = 1'b1;
    while (moving) begin
      l = 2 * s;
      r = l + 1;
      m = s;
      if (l <= entry_total && slot_pri[l] < slot_pri[s]) begin
        m = (r <= entry_total && slot_pri[r] < slot_pri[l]) ? r : l;
      end else if (r <= entry_total && slot_pri[r] < slot_pri[s]) begin
        m = r;
      end
      if (m == s) begin
        moving = 1'b0;
      end else begin
        swap_slots(m, s);
        s = m;
      end
    end
  endfunction

  function automatic heap_reply_t next_heap_reply(imh_pkg::action_t act, logic [KW-1:0] key,
                                                  logic [PW-1:0] pri);
    heap_reply_t r;
    int s;
    r = '{imh_pkg::ST_OK, '0, '0};
    case (act)
      imh_pkg::ACT_INSERT: begin
        // duplicate check comes before the capacity check
        if (key_slot[key] != 0) begin
          r.status = imh_pkg::ST_KEY;
        end else if (entry_total >= CAP) begin
          r.status = imh_pkg::ST_FULL;
        end else begin
          entry_total++;
          slot_key[entry_total] = key;
          slot_pri[entry_total] = pri;
          key_slot[key] = SLW'(entry_total);
          climb(entry_total);
        end
      end
      imh_pkg::ACT_DECREASE: begin
        s = key_slot[key];
        if (s == 0 || s > entry_total) begin
          r.status = imh_pkg::ST_KEY;
        end else begin
          // a larger value is written too, but the entry only ever climbs
          slot_pri[s] = pri;
          climb(s);
        end
      end
      imh_pkg::ACT_EXTRACT: begin
        if (entry_total == 0) begin
          r.status = imh_pkg::ST_EMPTY;
        end else begin
          r.key = slot_key[1];
          r.pri = slot_pri[1];
          key_slot[r.key] = '0;
          if (entry_total > 1) begin
            slot_key[1] = slot_key[entry_total];
            slot_pri[1] = slot_pri[entry_total];
            key_slot[slot_key[1]] = SLW'(1);
          end
          entry_total--;
          sink(1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void flag_reply(string what, heap_reply_t want, heap_reply_t got);
    failures++;
    if (failures <= REPORT_LIMIT) begin
      $display("%0t: %s: expected status %0d key %0d priority %h,",
               $time, what, want.status, want.key, want.pri,
               " got status %0d key %0d priority %h", got.status, got.key, got.pri);
    end
  endfunction

  always @(posedge clk) begin : watch
    heap_reply_t want;
    heap_reply_t got;
    heap_reply_t due;
    if (!rst_n) begin
      entry_total = 0;
      foreach (key_slot[i]) key_slot[i] = '0;
      replies_due.delete();
    end else begin
      // retire the reply first: it can never belong to a request taken this edge
      if (out_tvalid && out_tready) begin
        got = '{imh_pkg::status_t'(out_tuser), out_tdata[7:0], out_tdata[39:8]};
        if (replies_due.size() == 0) begin
          flag_reply("reply with no request outstanding", '0, got);
        end else begin
          want = replies_due.pop_front();
          if (got !== want) flag_reply("reply mismatch", want, got);
        end
      end
      if (in_tvalid && in_tready) begin
        due = next_heap_reply(imh_pkg::action_t'(in_tuser), in_tdata[7:0], in_tdata[39:8]);
        replies_due = {replies_due, due};
      end
    end
    fail_count <= failures;
    pending    <= replies_due.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Indexed min-heap unit testbench
// Drives insert, decrease-key, extract and unused-code requests into the heap unit with
// random gaps and receiver stalls: a directed opening over the corner cases,
// then fill-and-drain and mixed random rounds. The reply checker predicts and
// compares every reply; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 1700;
  localparam int LONG_STALL     = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int KW             = imh_pkg::KEY_W;
  localparam int PW             = imh_pkg::PRIO_W;
  localparam int NK             = imh_pkg::NKEYS;
  localparam int CAP            = imh_pkg::CAPACITY;

  typedef struct {
    imh_pkg::action_t act;
    logic [KW-1:0]    key;
  } sent_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [7:0] key, [39:8] priority_req
  logic [1:0]  in_tuser;   // [1:0] action
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [7:0] out_key, [39:8] out_priority
  logic [1:0]  out_tuser;  // [1:0] status

  int fail_count;
  int pending;

  // Rough view of which keys sit in the heap, kept only to shape requests.
  bit        key_live [0:NK-1];
  int        live_count;
  sent_req_t sent_log[$];

  int items_sent;
  int stall_asked;
  int stall_served;
  bit no_gaps;
  int quiet_cycles;

  indexed_min_heap_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  imh_reply_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [PW-1:0] draw_priority();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return PW'($urandom_range(0, 15));
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return '1;
        2:       return 32'h8000_0000;
        default: return 32'h7fff_ffff;
      endcase
    end
    return PW'($urandom);
  endfunction

  function automatic logic [KW-1:0] pick_key(bit want_live);
    int base;
    base = $urandom_range(0, NK - 1);
    for (int i = 0; i < NK; i++) begin
      if (key_live[(base + i) % NK] == want_live) return KW'((base + i) % NK);
    end
    return KW'(base);
  endfunction

  task automatic issue(imh_pkg::action_t act, logic [KW-1:0] key, logic [PW-1:0] pri);
    int g;
    sent_req_t req;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {pri, key};
    do @(posedge clk); while (!in_tready);
    req = '{act, key};
    sent_log = {sent_log, req};
    items_sent++;
    g = no_gaps ? 0 : pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Hold off the sender until every reply has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_request(int w_ins, int w_dec, int w_ext);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_ins) begin
      issue(imh_pkg::ACT_INSERT, ($urandom_range(0, 9) == 0) ? KW'($urandom) : pick_key(1'b0),
            draw_priority());
    end else if (r < w_ins + w_dec) begin
      issue(imh_pkg::ACT_DECREASE, ($urandom_range(0, 9) == 0) ? KW'($urandom) : pick_key(1'b1),
            draw_priority());
    end else if (r < w_ins + w_dec + w_ext) begin
      issue(imh_pkg::ACT_EXTRACT, KW'($urandom), PW'($urandom));
    end else begin
      issue(imh_pkg::action_t'(2'($urandom_range(0, 3))), KW'($urandom), PW'($urandom));
    end
  endtask

  // Track accepted inserts and extracts from the replies.
  always @(posedge clk) begin : reply_tracker
    sent_req_t req;
    if (rst_n && out_tvalid && out_tready && sent_log.size() != 0) begin
      req = sent_log.pop_front();
      if (imh_pkg::status_t'(out_tuser) == imh_pkg::ST_OK) begin
        if (req.act == imh_pkg::ACT_INSERT && !key_live[req.key]) begin
          key_live[req.key] = 1'b1;
          live_count++;
        end else if (req.act == imh_pkg::ACT_EXTRACT && key_live[out_tdata[7:0]]) begin
          key_live[out_tdata[7:0]] = 1'b0;
          live_count--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int hold;
    int run;
    out_tready = 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      if (stall_served != stall_asked) begin
        stall_served = stall_asked;
        hold = LONG_STALL;
      end else begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  initial begin : request_source
    int tries;
    int len;
    int mode;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = imh_pkg::ACT_NONE;
    items_sent   = 0;
    stall_asked  = 0;
    no_gaps      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty, absent, unused code, extremes, ties.
    issue(imh_pkg::ACT_EXTRACT,  8'd0,   32'd0);
    issue(imh_pkg::ACT_DECREASE, 8'd7,   32'd3);
    issue(imh_pkg::ACT_NONE,     8'd255, 32'hffff_ffff);
    issue(imh_pkg::ACT_INSERT,   8'd0,   32'd0);
    issue(imh_pkg::ACT_INSERT,   8'd255, 32'hffff_ffff);
    issue(imh_pkg::ACT_INSERT,   8'd0,   32'd5);
    issue(imh_pkg::ACT_DECREASE, 8'd0,   32'h8000_0000);
    issue(imh_pkg::ACT_DECREASE, 8'd255, 32'd0);
    issue(imh_pkg::ACT_INSERT,   8'd10,  32'd5);
    issue(imh_pkg::ACT_INSERT,   8'd11,  32'd5);
    issue(imh_pkg::ACT_INSERT,   8'd12,  32'd5);
    issue(imh_pkg::ACT_NONE,     8'd0,   32'd0);
    repeat (6) issue(imh_pkg::ACT_EXTRACT, 8'd0, 32'd0);
    issue(imh_pkg::ACT_DECREASE, 8'd255, 32'd1);
    issue(imh_pkg::ACT_INSERT,   8'd128, 32'h5555_5555);
    issue(imh_pkg::ACT_INSERT,   8'd127, 32'haaaa_aaaa);
    issue(imh_pkg::ACT_DECREASE, 8'd127, 32'h5555_5555);
    issue(imh_pkg::ACT_EXTRACT,  8'd0,   32'd0);
    issue(imh_pkg::ACT_EXTRACT,  8'd0,   32'd0);
    wait_drained();

    // Fill to capacity: every key is then held, so further inserts collide.
    tries = 0;
    while (live_count < CAP && tries < 3 * CAP) begin
      issue(imh_pkg::ACT_INSERT, pick_key(1'b0), draw_priority());
      tries++;
    end
    wait_drained();
    repeat (4) issue(imh_pkg::ACT_INSERT, KW'($urandom), draw_priority());
    repeat (20) issue(imh_pkg::ACT_DECREASE, pick_key(1'b1), draw_priority());
    tries = 0;
    while (live_count > 0 && tries < 3 * CAP) begin
      random_request(0, 20, 80);
      tries++;
    end
    wait_drained();
    issue(imh_pkg::ACT_EXTRACT, 8'd0, 32'd0);

    // Long receiver hold-off while requests keep coming.
    stall_asked++;
    in_tvalid <= 1'b0;
    wait (stall_served == stall_asked);
    no_gaps = 1'b1;
    repeat (30) random_request(50, 30, 18);
    no_gaps = 1'b0;
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      mode    = $urandom_range(0, 9);
      len     = $urandom_range(20, 60);
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 11) == 0) stall_asked++;
      case (mode)
        0, 1, 2, 3: repeat (len) random_request(40, 30, 27);
        4, 5, 6:    repeat (len) random_request(65, 20, 12);
        default:    repeat (len) random_request(10, 20, 67);
      endcase
      no_gaps = 1'b0;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
